### rtl/bml_pkg.sv
// Package with shared types and constants of the battery level moving average block.
`timescale 1ns / 1ps

package bml_pkg;

	// Threshold register width and reset values
	localparam int THR_BITS = 12;
	localparam logic [THR_BITS-1:0] LOW_THR_RESET    = 12'd2374;
	localparam logic [THR_BITS-1:0] MEDIUM_THR_RESET = 12'd2482;
	localparam logic [THR_BITS-1:0] HIGH_THR_RESET   = 12'd2560;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LOW    = 2'd0;
	localparam cfg_idx_t CFG_MEDIUM = 2'd1;
	localparam cfg_idx_t CFG_HIGH   = 2'd2;

	// Field widths of the streams
	localparam int SAMPLE_FIELD_BITS = 12;
	localparam int IN_TDATA_BITS     = 16;
	localparam int AVG_FIELD_BITS    = 12;
	localparam int LED_BITS          = 4;
	localparam int OUT_TDATA_BITS    = 24;

	// Battery level codes
	typedef enum logic [1:0] {
		LVL_LOW,
		LVL_MEDIUM,
		LVL_HIGH,
		LVL_FULL
	} level_t;

	// LED bar patterns
	localparam logic [LED_BITS-1:0] LED_LOW    = 4'd8;
	localparam logic [LED_BITS-1:0] LED_MEDIUM = 4'd10;
	localparam logic [LED_BITS-1:0] LED_HIGH   = 4'd11;
	localparam logic [LED_BITS-1:0] LED_FULL   = 4'd15;

	// Map a level to its LED bar pattern
	function automatic logic [LED_BITS-1:0] led_of(input level_t lvl);
		logic [LED_BITS-1:0] led;
		case (lvl)
			LVL_LOW:    led = LED_LOW;
			LVL_MEDIUM: led = LED_MEDIUM;
			LVL_HIGH:   led = LED_HIGH;
			default:    led = LED_FULL;
		endcase
		return led;
	endfunction

endpackage

### rtl/battery_level_moving_average.sv
// Top level: moving average of battery ADC samples with level thresholds.
`timescale 1ns / 1ps
//
// Usage
//   s_tvalid/s_tready/s_tdata carry one raw ADC sample per request. Each
//   accepted sample replaces the oldest entry of a WINDOW-deep ring held in a
//   synchronous memory; a running sum of the ring is kept beside it.
//   m_tvalid/m_tready/m_tdata return one result per sample: the floor of the
//   window sum divided by WINDOW, a level from 0 to 3 and a four-LED bar.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the three thresholds; write
//   them only while no sample is in flight. cfg_ready is always high.
// Throughput and stages
//   One sample per cycle while the output is not stalled. Each sample passes
//   memory read, sum update, reciprocal multiply and threshold compare.
//   Each sample touches the ring entry after the previous one, so the
//   read-before-write of the memory port needs no forwarding.
// Reset
//   arst_n clears the write pointer, the sum and the per-entry valid bits, so
//   the ring reads as zeros during warm-up. Thresholds return to their
//   defaults. No clearing pass is needed.
// Backpressure
//   When the result waits with m_tready low, the whole pipeline holds and
//   s_tready drops in the same cycle.
module battery_level_moving_average #(
	parameter int WINDOW      = 20,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// tdata: sample[11:0], zero fill [15:12]
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bml_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	// tdata: average_code[11:0], level[13:12], led_bar[17:14], zero fill [23:18]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bml_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  bml_pkg::cfg_idx_t                    cfg_index,
	input  logic [bml_pkg::THR_BITS-1:0]         cfg_data
);
	import bml_pkg::*;

	localparam int PTR_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LOG_W      = $clog2(WINDOW);
	localparam int SUM_BITS   = SAMPLE_BITS + LOG_W;
	localparam int SHIFT      = SUM_BITS + LOG_W;
	localparam int RECIP_BITS = SHIFT + 1;
	localparam int RECIP_INT  = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_INT);
	localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
	localparam int WIDE_BITS  = 16;
	localparam logic [SUM_BITS-1:0] SUM_MAX =
		SUM_BITS'(WINDOW * ((1 << SAMPLE_BITS) - 1));

	// Threshold registers
	logic [THR_BITS-1:0] low_thr_q, medium_thr_q, high_thr_q;

	// Ring memory and its per-entry valid bits
	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
	logic [WINDOW-1:0]      filled_q;
	logic [PTR_BITS-1:0]    wptr_q;
	logic [SUM_BITS-1:0]    sum_q;

	// Pipeline registers
	logic                   v_s1, v_s2, v_s3;
	logic [SAMPLE_BITS-1:0] sample_s1, old_rd_s1;
	logic                   old_ok_s1;
	logic [SUM_BITS-1:0]    sum_s2;
	logic [SAMPLE_BITS-1:0] avg_s3;
	logic                   out_valid_q;
	logic [AVG_FIELD_BITS-1:0] out_avg_q;
	level_t                 out_level_q;
	logic [LED_BITS-1:0]    out_led_q;

	logic                   adv;
	logic                   s_acc;
	logic [WIDE_BITS-1:0]   sample_wide;
	logic [SAMPLE_BITS-1:0] sample_in;
	logic [SAMPLE_BITS-1:0] old_s1;
	logic [SUM_BITS-1:0]    sum_next;
	logic [PROD_BITS-1:0]   prod_s2;
	logic [WIDE_BITS-1:0]   avg_wide;
	level_t                 level_s3;

	// Handshake: the pipeline moves when the output slot is free or taken
	assign adv       = !out_valid_q || m_tready;
	assign s_tready  = adv;
	assign s_acc     = s_tvalid && adv;
	assign cfg_ready = 1'b1;

	// Drop sample bits above SAMPLE_BITS
	assign sample_wide = WIDE_BITS'(s_tdata[SAMPLE_FIELD_BITS-1:0]);
	assign sample_in   = sample_wide[SAMPLE_BITS-1:0];

	// Write thresholds, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q    <= LOW_THR_RESET;
			medium_thr_q <= MEDIUM_THR_RESET;
			high_thr_q   <= HIGH_THR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOW:    low_thr_q    <= cfg_data;
				CFG_MEDIUM: medium_thr_q <= cfg_data;
				CFG_HIGH:   high_thr_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Read the oldest entry and overwrite it with the new sample
	always_ff @(posedge clk) begin
		if (s_acc) begin
			old_rd_s1         <= ring_mem[wptr_q];
			ring_mem[wptr_q]  <= sample_in;
		end
	end

	// Advance pointer, valid bits and stage-one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			filled_q  <= '0;
			old_ok_s1 <= 1'b0;
		end else if (s_acc) begin
			old_ok_s1        <= filled_q[wptr_q];
			filled_q[wptr_q] <= 1'b1;
			if (wptr_q == PTR_BITS'(WINDOW - 1)) begin
				wptr_q <= '0;
			end else begin
				wptr_q <= wptr_q + 1'b1;
			end
		end
	end

	// Stage one payload: hold the sample beside the memory read
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sample_s1 <= sample_in;
		end
	end

	// An entry never written reads as zero
	assign old_s1   = old_ok_s1 ? old_rd_s1 : '0;
	assign sum_next = sum_q - SUM_BITS'(old_s1) + SUM_BITS'(sample_s1);

	// Update the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv && v_s1) begin
			sum_q <= sum_next;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Divide by WINDOW with a reciprocal multiply
	assign prod_s2 = PROD_BITS'(sum_s2) * PROD_BITS'(RECIP);

	// Compare the average with the thresholds in order
	always_comb begin
		if (WIDE_BITS'(avg_s3) < WIDE_BITS'(low_thr_q)) begin
			level_s3 = LVL_LOW;
		end else if (WIDE_BITS'(avg_s3) < WIDE_BITS'(medium_thr_q)) begin
			level_s3 = LVL_MEDIUM;
		end else if (WIDE_BITS'(avg_s3) < WIDE_BITS'(high_thr_q)) begin
			level_s3 = LVL_HIGH;
		end else begin
			level_s3 = LVL_FULL;
		end
	end

	assign avg_wide = WIDE_BITS'(avg_s3);

	// Payload stages two, three and the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2      <= sum_next;
			avg_s3      <= prod_s2[SHIFT +: SAMPLE_BITS];
			out_avg_q   <= avg_wide[AVG_FIELD_BITS-1:0];
			out_level_q <= level_s3;
			out_led_q   <= led_of(level_s3);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_BITS - AVG_FIELD_BITS - 2 - LED_BITS){1'b0}},
		out_led_q, out_level_q, out_avg_q};

	// An accepted sample marks its ring entry as written
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> filled_q[$past(wptr_q)])
		else $error("ring entry not marked after write");

	// The write pointer stays inside the ring
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= PTR_BITS'(WINDOW - 1))
		else $error("write pointer out of range");

	// The running sum never exceeds a full window of maximum samples
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("running sum out of range");

	// With the receiver ready, a result follows its sample through v_s1, v_s2, v_s3 and out_valid_q
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after pipeline latency");

	// A write to the low threshold takes effect on the next cycle
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == CFG_LOW) |=> low_thr_q == $past(cfg_data))
		else $error("low threshold write lost");

endmodule
